/* hw/rtl/alle_pkg.sv */
// Package for the array linked list engine.
// Holds the command and status codes and the beat payload types.
// No dependencies.
package alle_pkg;

  localparam logic [2:0] CMD_READ   = 3'd0;
  localparam logic [2:0] CMD_MODIFY = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_INS_AF = 3'd3;
  localparam logic [2:0] CMD_INS_FR = 3'd4;
  localparam logic [2:0] CMD_INS_BK = 3'd5;
  localparam logic [2:0] CMD_SEARCH = 3'd6;
  localparam logic [2:0] CMD_FIRST  = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_INV  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [3:0]  position;
    logic        position_valid;
    logic [31:0] value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] data;
    logic [3:0]  index;
    logic        index_valid;
    logic [4:0]  count;
  } out_beat_t;

endpackage

/* hw/rtl/alle_ram.sv */
// Simple dual port RAM: one write port, one read port with registered data.
// Used for the element store and the link store. No dependencies.
module alle_ram #(
  parameter int AW = 4,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/array_linked_list_engine.sv */
// Top level of the array linked list engine: sequencer, list pointers, output register.
// Depends on alle_pkg and alle_ram.
//
// Usage: one command beat enters on in_valid/in_stall (payload in_data) and gives
// exactly one result beat on out_valid/out_stall (payload out_data). The block takes
// one command at a time; in_stall stays high from acceptance until the result has
// moved into the output register.
// Delete elsewhere than at the head walks the links to the predecessor, and search
// visits nodes until a match or the end of the list. The walks of delete and search
// are bound by the link store read port: one link per cycle through a registered
// RAM read.
// Reset clears head, tail, count, free list head and the fill mark at once; the link
// store needs no clearing pass, since slots at and above the fill mark are handed out in
// order and are never read before they are written.
// When the receiver stalls, the finished result is held in the output register and
// the next command is still accepted; its result waits until the register frees up.
module array_linked_list_engine
  import alle_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int LW = $clog2(DEPTH + 1);
  localparam int EW = ELEM_WIDTH;
  localparam logic [LW-1:0] NIL = LW'(DEPTH);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_MOD   = 4'd3;
  localparam logic [3:0] S_DEL1  = 4'd4;
  localparam logic [3:0] S_DWALK = 4'd5;
  localparam logic [3:0] S_DFREE = 4'd6;
  localparam logic [3:0] S_ALLOC = 4'd7;
  localparam logic [3:0] S_INS3A = 4'd8;
  localparam logic [3:0] S_INS3B = 4'd9;
  localparam logic [3:0] S_INS5  = 4'd10;
  localparam logic [3:0] S_SRCH  = 4'd11;
  localparam logic [3:0] S_DONE  = 4'd12;

  logic [3:0]       state_r, state_nxt;
  logic [2:0]       cmd_r, cmd_nxt;
  logic [3:0]       pos_r, pos_nxt;
  logic             posv_r, posv_nxt;
  logic [EW-1:0]    val_r, val_nxt;
  logic [LW-1:0]    head_r, head_nxt;
  logic [LW-1:0]    tail_r, tail_nxt;
  logic [LW-1:0]    fh_r, fh_nxt;
  logic [LW-1:0]    wm_r, wm_nxt;
  logic [LW-1:0]    cnt_r, cnt_nxt;
  logic [DEPTH-1:0] inl_r, inl_nxt;
  logic [LW-1:0]    p_r, p_nxt;
  logic [LW-1:0]    n_r, n_nxt;
  logic [EW-1:0]    old_r, old_nxt;
  out_beat_t        res_r, res_nxt;
  out_beat_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic          e_we;
  logic [AW-1:0] e_waddr, e_raddr;
  logic [EW-1:0] e_wdata, e_rdata;
  logic          l_we;
  logic [AW-1:0] l_waddr, l_raddr;
  logic [LW-1:0] l_wdata, l_rdata;

  logic [31:0]   pos32;
  logic [AW-1:0] pos_a;
  logic [LW-1:0] pos_l;
  logic [63:0]   val64;
  logic          pos_ok;
  logic          pos_head;
  logic          pos_tail;

  alle_ram #(.AW(AW), .DW(EW)) u_elem (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  alle_ram #(.AW(AW), .DW(LW)) u_link (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  function automatic out_beat_t mk_res(logic [1:0] st, logic [EW-1:0] d,
                                       logic [LW-1:0] idx, logic iv);
    out_beat_t r;
    logic [63:0] d64;
    logic [31:0] i32;
    d64 = 64'(d);
    i32 = 32'(idx);
    r.status      = st;
    r.data        = d64[31:0];
    r.index       = iv ? i32[3:0] : 4'd0;
    r.index_valid = iv;
    r.count       = 5'd0;
    return r;
  endfunction

  function automatic logic is_slot(logic [LW-1:0] x);
    return 32'(x) < DEPTH;
  endfunction

  assign pos32    = 32'(pos_r);
  assign pos_a    = pos32[AW-1:0];
  assign pos_l    = pos32[LW-1:0];
  assign val64    = 64'(in_data.value);
  assign pos_ok   = posv_r && (pos32 < DEPTH) && inl_r[pos_a];
  assign pos_head = (head_r == pos_l);
  assign pos_tail = (tail_r == pos_l);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    logic [31:0] n32;
    logic [31:0] c32;
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    pos_nxt       = pos_r;
    posv_nxt      = posv_r;
    val_nxt       = val_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fh_nxt        = fh_r;
    wm_nxt        = wm_r;
    cnt_nxt       = cnt_r;
    inl_nxt       = inl_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    old_nxt       = old_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    e_we          = 1'b0;
    e_waddr       = pos_a;
    e_wdata       = val_r;
    e_raddr       = pos_a;
    l_we          = 1'b0;
    l_waddr       = pos_a;
    l_wdata       = n_r;
    l_raddr       = pos_a;
    n32           = 32'(fh_r);
    c32           = 32'(cnt_r);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_data.cmd;
          pos_nxt   = in_data.position;
          posv_nxt  = in_data.position_valid;
          val_nxt   = val64[EW-1:0];
          state_nxt = S_START;
        end
      end
      S_START: begin
        unique case (cmd_r) inside
          CMD_READ, CMD_MODIFY, CMD_DELETE: begin
            // element and link of pos come back next cycle
            if (!pos_ok) begin
              res_nxt   = mk_res(ST_INV, '0, '0, 1'b0);
              state_nxt = S_DONE;
            end else if (cmd_r == CMD_READ) begin
              state_nxt = S_READ;
            end else if (cmd_r == CMD_MODIFY) begin
              state_nxt = S_MOD;
            end else begin
              state_nxt = S_DEL1;
            end
          end
          CMD_INS_AF, CMD_INS_FR, CMD_INS_BK: begin
            l_raddr = n32[AW-1:0];
            if (cmd_r == CMD_INS_AF && !pos_ok) begin
              res_nxt   = mk_res(ST_INV, '0, '0, 1'b0);
              state_nxt = S_DONE;
            end else if (fh_r == NIL) begin
              res_nxt   = mk_res(ST_FULL, '0, '0, 1'b0);
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_ALLOC;
            end
          end
          CMD_SEARCH: begin
            e_raddr = head_r[AW-1:0];
            l_raddr = head_r[AW-1:0];
            p_nxt   = head_r;
            if (head_r == NIL) begin
              res_nxt   = mk_res(ST_OK, '0, '0, 1'b0);
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_SRCH;
            end
          end
          default: begin
            res_nxt   = mk_res(ST_OK, '0, head_r, is_slot(head_r));
            state_nxt = S_DONE;
          end
        endcase
      end
      S_READ: begin
        res_nxt   = mk_res(ST_OK, e_rdata, '0, 1'b0);
        state_nxt = S_DONE;
      end
      S_MOD: begin
        e_we      = 1'b1;
        res_nxt   = mk_res(ST_OK, e_rdata, '0, 1'b0);
        state_nxt = S_DONE;
      end
      S_DEL1: begin
        old_nxt = e_rdata;
        n_nxt   = l_rdata;
        if (pos_head) begin
          head_nxt = l_rdata;
          if (pos_tail) begin
            tail_nxt = NIL;
          end
          state_nxt = S_DFREE;
        end else begin
          p_nxt     = head_r;
          l_raddr   = head_r[AW-1:0];
          state_nxt = S_DWALK;
        end
      end
      S_DWALK: begin
        // l_rdata holds the link of p_r; stop at the predecessor of pos
        if (l_rdata == pos_l) begin
          l_we    = 1'b1;
          l_waddr = p_r[AW-1:0];
          l_wdata = n_r;
          if (pos_tail) begin
            tail_nxt = p_r;
          end
          state_nxt = S_DFREE;
        end else if (!is_slot(l_rdata)) begin
          res_nxt   = mk_res(ST_INV, '0, '0, 1'b0);
          state_nxt = S_DONE;
        end else begin
          p_nxt   = l_rdata;
          l_raddr = l_rdata[AW-1:0];
        end
      end
      S_DFREE: begin
        l_we             = 1'b1;
        l_wdata          = fh_r;
        fh_nxt           = pos_l;
        inl_nxt[pos_a]   = 1'b0;
        cnt_nxt          = cnt_r - LW'(1);
        res_nxt          = mk_res(ST_OK, old_r, n_r, is_slot(n_r));
        state_nxt        = S_DONE;
      end
      S_ALLOC: begin
        // slots at the fill mark have never been linked: their successor is mark + 1
        if (fh_r == wm_r) begin
          fh_nxt = fh_r + LW'(1);
          wm_nxt = wm_r + LW'(1);
        end else begin
          fh_nxt = l_rdata;
        end
        n_nxt   = fh_r;
        e_we    = 1'b1;
        e_waddr = n32[AW-1:0];
        if (n32 < DEPTH) begin
          inl_nxt[n32[AW-1:0]] = 1'b1;
        end
        cnt_nxt = cnt_r + LW'(1);
        unique case (cmd_r) inside
          CMD_INS_AF: begin
            state_nxt = S_INS3A;
          end
          CMD_INS_FR: begin
            l_we     = 1'b1;
            l_waddr  = n32[AW-1:0];
            l_wdata  = head_r;
            head_nxt = fh_r;
            if (tail_r == NIL) begin
              tail_nxt = fh_r;
            end
            res_nxt   = mk_res(ST_OK, '0, fh_r, 1'b1);
            state_nxt = S_DONE;
          end
          default: begin
            l_we      = 1'b1;
            l_waddr   = n32[AW-1:0];
            l_wdata   = NIL;
            state_nxt = S_INS5;
          end
        endcase
      end
      S_INS3A: begin
        l_we      = 1'b1;
        l_waddr   = n_r[AW-1:0];
        l_wdata   = l_rdata;
        state_nxt = S_INS3B;
      end
      S_INS3B: begin
        l_we = 1'b1;
        if (pos_tail) begin
          tail_nxt = n_r;
        end
        res_nxt   = mk_res(ST_OK, '0, n_r, 1'b1);
        state_nxt = S_DONE;
      end
      S_INS5: begin
        if (tail_r != NIL) begin
          l_we    = 1'b1;
          l_waddr = tail_r[AW-1:0];
        end
        tail_nxt = n_r;
        if (head_r == NIL) begin
          head_nxt = n_r;
        end
        res_nxt   = mk_res(ST_OK, '0, n_r, 1'b1);
        state_nxt = S_DONE;
      end
      S_SRCH: begin
        if (e_rdata == val_r) begin
          res_nxt   = mk_res(ST_OK, '0, p_r, 1'b1);
          state_nxt = S_DONE;
        end else if (!is_slot(l_rdata)) begin
          res_nxt   = mk_res(ST_OK, '0, '0, 1'b0);
          state_nxt = S_DONE;
        end else begin
          p_nxt   = l_rdata;
          e_raddr = l_rdata[AW-1:0];
          l_raddr = l_rdata[AW-1:0];
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_nxt       = res_r;
          out_nxt.count = c32[4:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= NIL;
      tail_r      <= NIL;
      fh_r        <= '0;
      wm_r        <= '0;
      cnt_r       <= '0;
      inl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fh_r        <= fh_nxt;
      wm_r        <= wm_nxt;
      cnt_r       <= cnt_nxt;
      inl_r       <= inl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r  <= cmd_nxt;
    pos_r  <= pos_nxt;
    posv_r <= posv_nxt;
    val_r  <= val_nxt;
    p_r    <= p_nxt;
    n_r    <= n_nxt;
    old_r  <= old_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= DEPTH)
    else $error("element count above depth");

  a_head_tail: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> ((head_r == NIL) == (tail_r == NIL)))
    else $error("head and tail disagree on empty list");

  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> ((cnt_r == '0) == (head_r == NIL)))
    else $error("count disagrees with head");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> ((fh_r == NIL) == (32'(cnt_r) == DEPTH)))
    else $error("free list disagrees with count");

  a_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE && (!out_valid_r || !out_stall) |=> out_valid_r && state_r == S_IDLE)
    else $error("finished result not loaded");

endmodule
